// ===== design/ewpq_pkg.sv =====
package ewpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 20;

    typedef enum logic [2:0] {
        OP_DRAIN     = 3'd0,
        OP_BYTE      = 3'd1,
        OP_WORD16    = 3'd2,
        OP_SIGNMAG16 = 3'd3,
        OP_SIGNMAG8  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POST,
        ST_FETCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [15:0] address;
        logic [7:0]  data;
    } entry_t;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_address;
        logic [7:0]  write_byte;
        logic        idle;
    } res_t;

endpackage

// ===== design/ewpq_cmd_if.sv =====
interface ewpq_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [15:0]        address;
    logic signed [15:0] value;
    logic               eeprom_ready;

    modport source (output valid, output opcode, output address, output value,
                    output eeprom_ready, input ready);
    modport sink (input valid, input opcode, input address, input value,
                  input eeprom_ready, output ready);
endinterface

// ===== design/ewpq_rsp_if.sv =====
interface ewpq_rsp_if;
    logic        valid;
    logic        ready;
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_byte;
    logic        idle;

    modport source (output valid, output write_valid, output write_address,
                    output write_byte, output idle, input ready);
    modport sink (input valid, input write_valid, input write_address,
                  input write_byte, input idle, output ready);
endinterface

// ===== design/ewpq_ring_mem.sv =====
module ewpq_ring_mem #(
    parameter int DEPTH = ewpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_idx,
    input  ewpq_pkg::entry_t         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_idx,
    output ewpq_pkg::entry_t         rd_data
);
    import ewpq_pkg::*;

    entry_t mem_array [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/eeprom_write_posting_queue_unit.sv =====
// Store of n bytes: accepted, then one ring write per cycle; the result item
// is registered at the last write, or held in the finish state until the
// output register is free, before the next item is taken. Drain that pops:
// one ring read, then the fetch state registers or holds the result likewise;
// any other drain or unused opcode answers from the idle state in the same way.
// The single write port of the ring memory sets the store rate.
// Reset clears both pointers and the control state; the ring is not cleared.
module eeprom_write_posting_queue_unit #(
    parameter int QUEUE_DEPTH = ewpq_pkg::QUEUE_DEPTH_DEF
) (
    input logic           clk,
    input logic           rst_n,
    ewpq_cmd_if.sink      cmd,
    ewpq_rsp_if.source    rsp
);
    import ewpq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        advance = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [1:0]       idx_reg, idx_next;
    logic [1:0]       cnt_reg;
    logic [15:0]      base_reg;
    logic [7:0]       bytes_reg [3];
    logic             ready_reg;
    res_t             hold_reg;
    res_t             out_reg;
    logic             out_valid_reg;

    logic             accept;
    logic             out_free;
    logic             out_load;
    res_t             out_data;
    logic             done;
    res_t             res;
    logic             is_drain;
    logic             is_post;
    logic             can_pop;
    logic [1:0]       post_cnt;
    logic [7:0]       byte_in [3];
    logic [15:0]      raw;
    logic             neg;
    logic [15:0]      mag;
    logic             mem_wr_en;
    logic             mem_rd_en;
    entry_t           mem_wr_data;
    entry_t           mem_rd_data;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign raw = $unsigned(cmd.value);
    assign neg = raw[15];
    assign mag = neg ? (~raw + 16'd1) : raw;
    assign can_pop = (wp_reg != rp_reg) && cmd.eeprom_ready;

    always_comb
    begin
        is_drain = 1'b0;
        is_post  = 1'b0;
        post_cnt = 2'd0;
        byte_in[0] = 8'd0;
        byte_in[1] = 8'd0;
        byte_in[2] = 8'd0;
        unique case (op_t'(cmd.opcode))
            OP_DRAIN:
            begin
                is_drain = 1'b1;
            end
            OP_BYTE:
            begin
                is_post    = 1'b1;
                post_cnt   = 2'd1;
                byte_in[0] = raw[7:0];
            end
            OP_WORD16:
            begin
                is_post    = 1'b1;
                post_cnt   = 2'd2;
                byte_in[0] = raw[7:0];
                byte_in[1] = raw[15:8];
            end
            OP_SIGNMAG16:
            begin
                is_post    = 1'b1;
                post_cnt   = 2'd3;
                byte_in[0] = mag[7:0];
                byte_in[1] = mag[15:8];
                byte_in[2] = {7'd0, neg};
            end
            OP_SIGNMAG8:
            begin
                is_post    = 1'b1;
                post_cnt   = 2'd2;
                byte_in[0] = mag[7:0];
                byte_in[1] = {7'd0, neg};
            end
            default:
            begin
                is_post = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_drain && can_pop)
                    begin
                        state_next = ST_FETCH;
                    end
                    else if (is_post)
                    begin
                        state_next = ST_POST;
                    end
                    else
                    begin
                        state_next = out_free ? ST_IDLE : ST_FINISH;
                    end
                end
            end
            ST_POST:
            begin
                if (idx_reg == cnt_reg - 2'd1)
                begin
                    state_next = out_free ? ST_IDLE : ST_FINISH;
                end
            end
            ST_FETCH:
            begin
                state_next = out_free ? ST_IDLE : ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = out_free ? ST_IDLE : ST_FINISH;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_wr_en = 1'b0;
        mem_rd_en = 1'b0;
        done      = 1'b0;
        res       = '0;
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        idx_next  = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = 2'd0;
                if (accept)
                begin
                    if (is_drain && can_pop)
                    begin
                        mem_rd_en = 1'b1;
                        rp_next   = advance(rp_reg);
                    end
                    else if (!is_post)
                    begin
                        done     = 1'b1;
                        res.idle = is_drain && (wp_reg == rp_reg) && cmd.eeprom_ready;
                    end
                end
            end
            ST_POST:
            begin
                mem_wr_en = 1'b1;
                wp_next   = advance(wp_reg);
                idx_next  = idx_reg + 2'd1;
                done      = (idx_reg == cnt_reg - 2'd1);
            end
            ST_FETCH:
            begin
                done              = 1'b1;
                res.write_valid   = 1'b1;
                res.write_address = mem_rd_data.address;
                res.write_byte    = mem_rd_data.data;
                res.idle          = (wp_reg == rp_reg) && ready_reg;
            end
            ST_FINISH:
            begin
                done = 1'b0;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    assign mem_wr_data.address = base_reg + {14'd0, idx_reg};
    assign mem_wr_data.data    = bytes_reg[idx_reg];

    assign out_load = (done || (state_reg == ST_FINISH)) && out_free;
    assign out_data = (state_reg == ST_FINISH) ? hold_reg : res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            idx_reg   <= idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cnt_reg      <= post_cnt;
            base_reg     <= cmd.address;
            bytes_reg[0] <= byte_in[0];
            bytes_reg[1] <= byte_in[1];
            bytes_reg[2] <= byte_in[2];
            ready_reg    <= cmd.eeprom_ready;
        end
        if (done && !out_free)
        begin
            hold_reg <= res;
        end
        if (out_load)
        begin
            out_reg <= out_data;
        end
    end

    ewpq_ring_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_idx  (wp_reg),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_idx  (rp_reg),
        .rd_data (mem_rd_data)
    );

    assign rsp.valid         = out_valid_reg;
    assign rsp.write_valid   = out_reg.write_valid;
    assign rsp.write_address = out_reg.write_address;
    assign rsp.write_byte    = out_reg.write_byte;
    assign rsp.idle          = out_reg.idle;

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("Ring read and write in the same cycle.");

    a_fetch_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> $past(mem_rd_en))
        else $error("Fetch state without a ring read.");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg <= PTR_LAST) && (rp_reg <= PTR_LAST))
        else $error("Pointer beyond the ring depth.");

    a_post_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POST) |-> (idx_reg < cnt_reg))
        else $error("Post index beyond the byte count.");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import ewpq_pkg::*;

    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1900;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST = 3'd7;
    localparam res_t NO_WRITE = '0;
    localparam res_t IDLE_ONLY = '{write_valid: 1'b0, write_address: 16'h0000,
                                   write_byte: 8'h00, idle: 1'b1};

    typedef struct {
        logic [2:0]         opcode;
        logic [15:0]        address;
        logic signed [15:0] value;
        logic               eeprom_ready;
        bit                 typed;
        res_t               reply;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ewpq_cmd_if cmd_ch ();
    ewpq_rsp_if rsp_ch ();

    eeprom_write_posting_queue_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd_ch),
        .rsp(rsp_ch)
    );

    logic [15:0] ring_address [QUEUE_DEPTH];
    logic [7:0]  ring_data [QUEUE_DEPTH];
    logic [4:0]  ring_wr_ptr;
    logic [4:0]  ring_rd_ptr;

    res_t        awaited_replies [$];
    stim_row_t   directed_rows [$];
    int          failures = 0;
    int          items_sent = 0;
    int          pops_seen = 0;
    int          idles_seen = 0;
    int          overfills = 0;
    int          stall_cycles = 0;
    bit          calm = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int ring_fill();
        return (int'(ring_wr_ptr) + QUEUE_DEPTH - int'(ring_rd_ptr)) % QUEUE_DEPTH;
    endfunction

    function automatic logic [4:0] ring_next(input logic [4:0] p);
        return (p == 5'(QUEUE_DEPTH - 1)) ? 5'd0 : p + 5'd1;
    endfunction

    function automatic void ring_post(input logic [15:0] addr, input logic [7:0] data);
        ring_address[ring_wr_ptr] = addr;
        ring_data[ring_wr_ptr] = data;
        ring_wr_ptr = ring_next(ring_wr_ptr);
    endfunction

    function automatic res_t step_write_queue(input logic [2:0] op, input logic [15:0] addr,
                                              input logic signed [15:0] val,
                                              input logic rdy);
        res_t        r;
        logic        neg;
        logic [16:0] mag;
        int          n;
        r = NO_WRITE;
        neg = val[15];
        mag = neg ? (17'h10000 - {1'b0, val}) : {1'b0, val};
        case (op)
            OP_BYTE:      n = 1;
            OP_WORD16:    n = 2;
            OP_SIGNMAG16: n = 3;
            OP_SIGNMAG8:  n = 2;
            default:      n = 0;
        endcase
        if (n > 0 && ring_fill() + n >= QUEUE_DEPTH)
            overfills++;
        case (op)
            OP_DRAIN:
            begin
                if (ring_wr_ptr != ring_rd_ptr && rdy)
                begin
                    r.write_valid = 1'b1;
                    r.write_address = ring_address[ring_rd_ptr];
                    r.write_byte = ring_data[ring_rd_ptr];
                    ring_rd_ptr = ring_next(ring_rd_ptr);
                end
                r.idle = (ring_wr_ptr == ring_rd_ptr) && rdy;
            end
            OP_BYTE:
                ring_post(addr, val[7:0]);
            OP_WORD16:
            begin
                ring_post(addr, val[7:0]);
                ring_post(addr + 16'd1, val[15:8]);
            end
            OP_SIGNMAG16:
            begin
                ring_post(addr, mag[7:0]);
                ring_post(addr + 16'd1, mag[15:8]);
                ring_post(addr + 16'd2, {7'd0, neg});
            end
            OP_SIGNMAG8:
            begin
                ring_post(addr, mag[7:0]);
                ring_post(addr + 16'd1, {7'd0, neg});
            end
            default:
                r = NO_WRITE;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 16'h0000;
        if (r < 6)
            return 16'hFFFF;
        if (r < 8)
            return 16'hFFFE;
        return 16'($urandom);
    endfunction

    function automatic logic signed [15:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 16'sh8000;
        if (r < 6)
            return 16'sh7FFF;
        if (r < 8)
            return 16'sh0000;
        if (r < 10)
            return 16'shFFFF;
        if (r < 12)
            return 16'sh0001;
        return 16'($urandom);
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [15:0] addr,
                             input logic signed [15:0] val, input logic rdy,
                             input bit typed, input res_t typed_reply);
        int   gap;
        res_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.opcode <= op;
        cmd_ch.address <= addr;
        cmd_ch.value <= val;
        cmd_ch.eeprom_ready <= rdy;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predicted = step_write_queue(op, addr, val, rdy);
        awaited_replies.push_back(typed ? typed_reply : predicted);
        items_sent++;
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int gap;
            gap = pick_gap();
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("result item arrived with nothing expected");
                failures++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (rsp_ch.write_valid !== want.write_valid)
                begin
                    $error("write_valid expected %0d actual %0d",
                           want.write_valid, rsp_ch.write_valid);
                    failures++;
                end
                if (rsp_ch.write_address !== want.write_address)
                begin
                    $error("write_address expected %h actual %h",
                           want.write_address, rsp_ch.write_address);
                    failures++;
                end
                if (rsp_ch.write_byte !== want.write_byte)
                begin
                    $error("write_byte expected %h actual %h",
                           want.write_byte, rsp_ch.write_byte);
                    failures++;
                end
                if (rsp_ch.idle !== want.idle)
                begin
                    $error("idle expected %0d actual %0d", want.idle, rsp_ch.idle);
                    failures++;
                end
                if (rsp_ch.write_valid === 1'b1)
                    pops_seen++;
                if (rsp_ch.idle === 1'b1)
                    idles_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int         counted;
        int         burst;
        int         r;
        int         drain_share;
        logic [2:0] op;
        logic       rdy;

        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.opcode = OP_DRAIN;
        cmd_ch.address = 16'h0000;
        cmd_ch.value = 16'sh0000;
        cmd_ch.eeprom_ready = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            ring_address[i] = 16'h0000;
            ring_data[i] = 8'h00;
        end
        ring_wr_ptr = 5'd0;
        ring_rd_ptr = 5'd0;

        directed_rows.push_back('{OP_DRAIN, 16'h0000, 16'sh0000, 1'b1, 1'b1, IDLE_ONLY});
        directed_rows.push_back('{OP_DRAIN, 16'hFFFF, 16'shFFFF, 1'b0, 1'b1, NO_WRITE});
        directed_rows.push_back('{OP_BYTE, 16'h0000, 16'sh00AB, 1'b1, 1'b1, NO_WRITE});
        directed_rows.push_back('{OP_BYTE, 16'hFFFF, 16'shFFFF, 1'b0, 1'b1, NO_WRITE});
        directed_rows.push_back('{OP_WORD16, 16'hFFFF, 16'sh1234, 1'b1, 1'b1, NO_WRITE});
        directed_rows.push_back('{OP_SIGNMAG16, 16'h1000, 16'sh8000, 1'b1, 1'b1, NO_WRITE});
        directed_rows.push_back('{OP_SIGNMAG16, 16'hFFFE, 16'sh7FFF, 1'b0, 1'b1, NO_WRITE});
        directed_rows.push_back('{OP_SIGNMAG8, 16'h0000, 16'shFFFF, 1'b1, 1'b1, NO_WRITE});
        directed_rows.push_back('{OP_SIGNMAG8, 16'h7FFF, 16'sh00FF, 1'b1, 1'b1, NO_WRITE});
        directed_rows.push_back('{OP_SPARE_FIRST, 16'hAAAA, 16'sh5555, 1'b1, 1'b1, NO_WRITE});
        directed_rows.push_back('{OP_SPARE_MID, 16'h5555, 16'shAAAA, 1'b1, 1'b1, NO_WRITE});
        directed_rows.push_back('{OP_SPARE_LAST, 16'hFFFF, 16'shFFFF, 1'b1, 1'b1, NO_WRITE});
        directed_rows.push_back('{OP_DRAIN, 16'h0000, 16'sh0000, 1'b0, 1'b1, NO_WRITE});
        directed_rows.push_back('{OP_DRAIN, 16'h0000, 16'sh0000, 1'b1, 1'b0, NO_WRITE});
        directed_rows.push_back('{OP_DRAIN, 16'h0000, 16'sh0000, 1'b1, 1'b0, NO_WRITE});
        directed_rows.push_back('{OP_SIGNMAG16, 16'h2000, 16'shFF00, 1'b1, 1'b0, NO_WRITE});
        directed_rows.push_back('{OP_SIGNMAG16, 16'h3000, 16'sh0100, 1'b1, 1'b0, NO_WRITE});
        directed_rows.push_back('{OP_SIGNMAG16, 16'h4000, 16'sh8001, 1'b1, 1'b0, NO_WRITE});
        directed_rows.push_back('{OP_DRAIN, 16'h0000, 16'sh0000, 1'b1, 1'b0, NO_WRITE});
        directed_rows.push_back('{OP_DRAIN, 16'h0000, 16'sh0000, 1'b1, 1'b0, NO_WRITE});
        directed_rows.push_back('{OP_DRAIN, 16'h0000, 16'sh0000, 1'b0, 1'b1, NO_WRITE});
        directed_rows.push_back('{OP_WORD16, 16'h0005, 16'sh8000, 1'b1, 1'b1, NO_WRITE});
        directed_rows.push_back('{OP_DRAIN, 16'h0000, 16'sh0000, 1'b1, 1'b0, NO_WRITE});
        directed_rows.push_back('{OP_DRAIN, 16'h0000, 16'sh0000, 1'b1, 1'b0, NO_WRITE});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].opcode, directed_rows[i].address,
                      directed_rows[i].value, directed_rows[i].eeprom_ready,
                      directed_rows[i].typed, directed_rows[i].reply);

        counted = 0;
        burst = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 119) == 0)
                calm = !calm;
            if (burst == 0 && $urandom_range(0, 199) == 0)
                burst = $urandom_range(6, 10);
            rdy = ($urandom_range(0, 99) >= 15);
            if (burst > 0)
            begin
                op = 3'($urandom_range(OP_BYTE, OP_SIGNMAG8));
                burst--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                drain_share = (ring_fill() > 14) ? 85 : (ring_fill() == 0 ? 25 : 50);
                if (r < 3)
                    op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
                else if (r < drain_share)
                    op = OP_DRAIN;
                else
                    op = 3'($urandom_range(OP_BYTE, OP_SIGNMAG8));
            end
            send_item(op, pick_address(), pick_value(), rdy, 1'b0, NO_WRITE);
            if (op < OP_SPARE_FIRST)
                counted++;
        end
        cmd_ch.valid <= 1'b0;

        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d command items: %0d entries written out, %0d idle reports.",
                 items_sent, pops_seen, idles_seen);
        $display("Stores that wrapped the ring over unread entries: %0d.", overfills);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
